// File: rtl/meb_pkg.sv
// Shared types, constants and helpers of the Mandelbrot escape-time block.
`timescale 1ns / 1ps
package meb_pkg;

  localparam int unsigned QW       = 32;   // Q8.24 word
  localparam int unsigned StepW    = 31;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ProdW    = IdxW + StepW;
  localparam int unsigned SumW     = 43;   // wide enough for every pre-saturation sum
  localparam int unsigned SqW      = 2 * QW;
  localparam int unsigned FracBits = 24;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [SqW-1:0]        EscBound = 64'd100 << 48;
  localparam logic signed [QW-1:0]  QMax     = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0]  QMin     = 32'sh8000_0000;
  localparam logic [CountW-1:0]     CountMax = 8'd255;

  typedef enum logic [1:0] {
    RegXStart = 2'd0,
    RegXStep  = 2'd1,
    RegYStart = 2'd2,
    RegYStep  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackMul,
    BackUpd,
    BackHold
  } back_state_e;

  typedef struct packed {
    logic signed [QW-1:0] x_start;
    logic [StepW-1:0]     x_step;
    logic signed [QW-1:0] y_start;
    logic [StepW-1:0]     y_step;
  } cfg_t;

  typedef struct packed {
    logic signed [QW-1:0] cx;
    logic signed [QW-1:0] cy;
  } coord_t;

  // Clamp a wide signed sum to the Q8.24 range.
  function automatic logic signed [QW-1:0] sat_q(input logic signed [SumW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > SumW'(QMax)) begin
      r = QMax;
    end else if (v < SumW'(QMin)) begin
      r = QMin;
    end else begin
      r = QW'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/meb_if.sv
// Valid/ready channel interfaces for pixel requests and escape counts.
`timescale 1ns / 1ps
interface meb_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] col;
  logic [9:0] row;

  modport source (output valid, output col, output row, input ready);
  modport sink   (input valid, input col, input row, output ready);
endinterface

interface meb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

// File: rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time pixel unit.
//
// Usage: write the window origin and per-pixel steps (signed Q8.24/unsigned
// Q7.24) through the APB-style port while the block is idle; each register
// access has a setup and an access phase and pready is always high. Then send
// pixel transactions (col, row) on pix_i. For each one the block forms
// c = (x_start + col*x_step, y_start + row*y_step), saturated to Q8.24, and
// iterates z = z^2 + c from zero until |z|^2 exceeds 100 or ITER_LIMIT
// iterations have run. One result transaction per pixel leaves on res_o, in
// order, carrying the iteration count (255 when the limit is reached).
//
// Flow: an accepted pixel's products are registered in the front end, its
// saturated point is pushed into the queue, and the engine takes it when idle.
// One shared complex-squaring unit runs each iteration as a square step
// (BackMul), then an add-and-saturate step (BackUpd). The engine works on one
// pixel at a time and takes the next once its count is in the output register.
// Reset clears all handshake state and loads the default window. A stalled
// result waits in the output register and the engine waits with the next count;
// the queue and front end take pixels until full, then pix_i.ready falls.
`timescale 1ns / 1ps
module mandelbrot_escape_time #(
  parameter int unsigned ITER_LIMIT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  meb_pix_if.sink                   pix_i,
  meb_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [meb_pkg::AddrW-1:0] paddr,
  input  logic [meb_pkg::DataW-1:0] pwdata,
  output logic [meb_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import meb_pkg::*;

  cfg_t   cfg;
  coord_t front_coord;
  coord_t q_coord;
  logic   front_push;
  logic   q_space;
  logic   q_valid;
  logic   q_pop;

  // Hold the window registers.
  meb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Map pixel indices to points in the complex plane.
  meb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .cfg_i   (cfg),
    .push_o  (front_push),
    .coord_o (front_coord),
    .space_i (q_space)
  );

  // Decouple the front end from the long-running engine.
  meb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_coord),
    .space_o (q_space),
    .valid_o (q_valid),
    .data_o  (q_coord),
    .pop_i   (q_pop)
  );

  // Iterate one point at a time and present its count.
  meb_back #(
    .ITER_LIMIT (ITER_LIMIT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_coord),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

// File: rtl/meb_cfg.sv
// APB-style register file holding the view window origin and step sizes.
`timescale 1ns / 1ps
module meb_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [meb_pkg::AddrW-1:0]  paddr,
  input  logic [meb_pkg::DataW-1:0]  pwdata,
  output logic [meb_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output meb_pkg::cfg_t              cfg_o
);
  import meb_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_start <= -32'sd58720256;
      cfg_q.x_step  <= 31'd125829;
      cfg_q.y_start <= -32'sd37748736;
      cfg_q.y_step  <= 31'd125829;
    end else if (wr_en) begin
      unique case (idx)
        RegXStart: cfg_q.x_start <= $signed(pwdata);
        RegXStep:  cfg_q.x_step  <= pwdata[StepW-1:0];
        RegYStart: cfg_q.y_start <= $signed(pwdata);
        RegYStep:  cfg_q.y_step  <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegXStart: prdata = cfg_q.x_start;
      RegXStep:  prdata = {1'b0, cfg_q.x_step};
      RegYStart: prdata = cfg_q.y_start;
      RegYStep:  prdata = {1'b0, cfg_q.y_step};
      default:   prdata = '0;
    endcase
  end

endmodule

// File: rtl/meb_front.sv
// Front end: accept a pixel, scale its indices and form the saturated point c.
`timescale 1ns / 1ps
module meb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  meb_pix_if.sink        pix_i,
  input  meb_pkg::cfg_t  cfg_i,
  output logic           push_o,
  output meb_pkg::coord_t coord_o,
  input  logic           space_i
);
  import meb_pkg::*;

  logic             s1_valid_q;
  logic [ProdW-1:0] prod_x_q;
  logic [ProdW-1:0] prod_y_q;
  logic             take;
  logic signed [SumW-1:0] sum_x;
  logic signed [SumW-1:0] sum_y;

  // Take a new pixel whenever the product stage is empty or drains this cycle.
  assign pix_i.ready = !s1_valid_q || space_i;
  assign take        = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (space_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_x_q <= ProdW'(pix_i.col) * ProdW'(cfg_i.x_step);
      prod_y_q <= ProdW'(pix_i.row) * ProdW'(cfg_i.y_step);
    end
  end

  assign sum_x = SumW'(cfg_i.x_start) + $signed({2'b00, prod_x_q});
  assign sum_y = SumW'(cfg_i.y_start) + $signed({2'b00, prod_y_q});

  assign push_o     = s1_valid_q;
  assign coord_o.cx = sat_q(sum_x);
  assign coord_o.cy = sat_q(sum_y);

endmodule

// File: rtl/meb_queue.sv
// Two-entry queue of points between the front end and the iteration engine.
`timescale 1ns / 1ps
module meb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  meb_pkg::coord_t data_i,
  output logic            space_o,
  output logic            valid_o,
  output meb_pkg::coord_t data_o,
  input  logic            pop_i
);
  import meb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  coord_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign space_o = cnt_q != CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/meb_back.sv
// Iteration engine: z = z^2 + c on one shared squaring unit, plus output register.
`timescale 1ns / 1ps
module meb_back #(
  parameter int unsigned ITER_LIMIT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  meb_pkg::coord_t q_data_i,
  output logic            q_pop_o,
  meb_res_if.source       res_o
);
  import meb_pkg::*;

  localparam int unsigned IterW = (ITER_LIMIT > 1) ? $clog2(ITER_LIMIT) : 1;

  back_state_e state_q, state_d;
  coord_t      c_q;
  logic signed [QW-1:0]  zx_q, zy_q;
  logic signed [SqW-1:0] sx_q, sy_q, xy_q;
  logic [IterW-1:0]      iter_q;
  logic [CountW-1:0]     cnt_q, cnt_d;
  logic                  out_valid_q;
  logic [CountW-1:0]     out_cnt_q;

  logic                  ld_c, upd, fin, out_ld, slot_free, esc, last;
  logic [SqW-1:0]        mag;
  logic signed [SqW-1:0] dif;
  logic signed [SumW-1:0] nx_w, ny_w;

  assign mag  = $unsigned(sx_q) + $unsigned(sy_q);
  assign esc  = mag > EscBound;
  assign last = iter_q == IterW'(ITER_LIMIT - 1);
  assign dif  = sx_q - sy_q;
  assign nx_w = SumW'(dif >>> FracBits) + SumW'(c_q.cx);
  assign ny_w = SumW'(xy_q >>> (FracBits - 1)) + SumW'(c_q.cy);

  assign slot_free          = !out_valid_q || res_o.ready;
  assign res_o.valid           = out_valid_q;
  assign res_o.iteration_count = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    ld_c    = 1'b0;
    upd     = 1'b0;
    fin     = 1'b0;
    out_ld  = 1'b0;
    cnt_d   = CountMax;
    unique case (state_q)
      BackIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ld_c    = 1'b1;
          state_d = BackMul;
        end
      end
      BackMul: begin
        state_d = BackUpd;
      end
      BackUpd: begin
        if (esc) begin
          fin     = 1'b1;
          cnt_d   = CountW'(iter_q);
          state_d = BackHold;
        end else begin
          upd = 1'b1;
          if (last) begin
            fin     = 1'b1;
            state_d = BackHold;
          end else begin
            state_d = BackMul;
          end
        end
      end
      BackHold: begin
        if (slot_free) begin
          out_ld  = 1'b1;
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  // x^2, y^2, x*y registered every cycle; z zeroed on load, updated in BackUpd.
  always_ff @(posedge clk_i) begin
    sx_q <= zx_q * zx_q;
    sy_q <= zy_q * zy_q;
    xy_q <= zx_q * zy_q;
    if (ld_c) begin
      c_q    <= q_data_i;
      zx_q   <= '0;
      zy_q   <= '0;
      iter_q <= '0;
    end else if (upd) begin
      zx_q   <= sat_q(nx_w);
      zy_q   <= sat_q(ny_w);
      iter_q <= iter_q + 1'b1;
    end
    if (fin) begin
      cnt_q <= cnt_d;
    end
    if (out_ld) begin
      out_cnt_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: rtl/meb_chk.sv
// Port-level checks of the escape-time block, bound to its top level.
`timescale 1ns / 1ps
module meb_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [7:0]                res_count,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic                      pready,
  input logic [meb_pkg::AddrW-1:0] paddr,
  input logic [meb_pkg::DataW-1:0] pwdata,
  input logic [meb_pkg::DataW-1:0] prdata
);

  // No result may be offered while reset is applied.
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid)
    else $error("result offered during reset");

  // A stalled result keeps its count.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_count))
    else $error("stalled result changed");

  // z starts at zero, so every pixel runs at least one iteration.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_count != 8'd0)
    else $error("zero iteration count");

  // A register read straight after a write returns the written value (steps are 31 bits).
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready)
    ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == ($past(paddr[2]) ? {1'b0, $past(pwdata[30:0])} : $past(pwdata)))
    else $error("register readback mismatch");

endmodule

bind mandelbrot_escape_time meb_chk u_meb_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_count (res_o.iteration_count),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
